[hw/rtl/owbm_pkg.sv]
// ----------------------------------------------------------------------------
// owbm_pkg
// Shared types, codes and helpers for the 1-Wire bus master.
// ----------------------------------------------------------------------------
package owbm_pkg;

   localparam int unsigned TimeWidth = 10;
   localparam int unsigned ByteWidth = 8;

   typedef logic [TimeWidth-1:0] time_type;

   // Operation codes carried with each tick
   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_RESET = 2'd1,
      OP_WRITE = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   // Register indexes on the control port
   typedef enum logic [2:0] {
      CSR_RECOVERY   = 3'd0,
      CSR_RESET_LOW  = 3'd1,
      CSR_RESET_HIGH = 3'd2,
      CSR_PRES_DELAY = 3'd3,
      CSR_PRES_WIN   = 3'd4,
      CSR_SLOT       = 3'd5,
      CSR_WRITE_ONE  = 3'd6,
      CSR_SAMPLE     = 3'd7
   } csr_index_type;

   // Reset values of the timing registers
   localparam time_type RecoveryReset  = 10'd5;
   localparam time_type ResetLowReset  = 10'd480;
   localparam time_type ResetHighReset = 10'd480;
   localparam time_type PresDelayReset = 10'd45;
   localparam time_type PresWinReset   = 10'd40;
   localparam time_type SlotReset      = 10'd60;
   localparam time_type WriteOneReset  = 10'd10;
   localparam time_type SampleReset    = 10'd5;

   // Bus sequencer phases
   typedef enum logic [3:0] {
      PH_IDLE  = 4'd0,
      PH_RREC  = 4'd1,
      PH_RLOW  = 4'd2,
      PH_RDLY  = 4'd3,
      PH_RWIN  = 4'd4,
      PH_RHIGH = 4'd5,
      PH_WSLOT = 4'd6,
      PH_WREC  = 4'd7,
      PH_RSLOT = 4'd8,
      PH_RDREC = 4'd9
   } phase_type;

   typedef struct packed {
      time_type recovery_time;
      time_type reset_low_time;
      time_type reset_high_time;
      time_type presence_delay;
      time_type presence_window;
      time_type slot_time;
      time_type write_one_low_time;
      time_type sample_delay;
   } cfg_type;

   typedef struct packed {
      logic [1:0]           operation;
      logic [ByteWidth-1:0] data_byte;
      logic                 line_level;
   } req_type;

   typedef struct packed {
      logic                 drive_low;
      logic                 busy_res;
      logic                 done_res;
      logic                 device_present;
      logic [ByteWidth-1:0] read_data;
      logic                 command_rejected;
   } rsp_type;

   // A zero length counts as one tick
   function automatic time_type at_least_one(input time_type v);
      return (v == '0) ? time_type'(1) : v;
   endfunction

   // Keep a point inside a slot: 1 .. len-1
   function automatic time_type clamp_in_slot(input time_type v, input time_type len);
      time_type top;
      top = len - time_type'(1);
      if (v == '0) return time_type'(1);
      if (v > top) return top;
      return v;
   endfunction

endpackage

[hw/rtl/one_wire_bus_master.sv]
// ----------------------------------------------------------------------------
// one_wire_bus_master
// Tick-driven 1-Wire master: reset/presence, byte write and byte read.
// ----------------------------------------------------------------------------
// Each request is one microsecond tick carrying the sampled bus level and an
// optional command; each request yields exactly one response that says whether
// to pull the bus low, the busy/done status, the last presence result and the
// last byte read. A request passes an input register, then the sequencer
// updates its phase, tick counter and shift byte and loads the response
// register, so one request is taken per clock unless rsp_ready stalls the
// response; the per-tick state update is the only loop. Timing registers
// are 10 bits; the user must write them on the csr_ port only while idle (unenforced).
// ----------------------------------------------------------------------------
module one_wire_bus_master (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  owbm_pkg::req_type     req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output owbm_pkg::rsp_type     rsp_payload,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [2:0]            csr_index,
   input  owbm_pkg::time_type    csr_data
);
   import owbm_pkg::*;

   cfg_type   cfg;

   logic      in_valid_ff;
   req_type   req_ff;
   logic      rsp_valid_ff;
   rsp_type   rsp_ff;
   rsp_type   rsp_in;
   logic      advance;

   phase_type            phase_ff,      phase_in;
   time_type             tick_count_ff, tick_count_in;
   logic [2:0]           bit_index_ff,  bit_index_in;
   logic [ByteWidth-1:0] shift_byte_ff, shift_byte_in;
   logic                 presence_ff,   presence_in;
   logic [ByteWidth-1:0] last_read_ff,  last_read_in;

   owbm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Pipeline flow control
   assign advance     = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || advance;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_payload;
      end
   end

   // Sequencer step for one tick
   always_comb begin
      phase_type            ph;
      phase_type            nxt;
      time_type             t;
      time_type             len;
      time_type             slen;
      time_type             low;
      logic [ByteWidth-1:0] sb;
      logic [2:0]           bi;
      logic                 pres;
      logic                 jump;
      logic                 fin;
      logic                 drive;
      logic                 done;
      logic                 rej;
      op_type               op;

      op   = op_type'(req_ff.operation);
      ph   = phase_ff;
      t    = tick_count_ff;
      bi   = bit_index_ff;
      sb   = shift_byte_ff;
      pres = presence_ff;
      rej  = 1'b0;
      drive = 1'b0;
      done  = 1'b0;
      jump  = 1'b0;
      fin   = 1'b0;
      len   = time_type'(1);
      nxt   = PH_IDLE;
      slen  = (cfg.slot_time < time_type'(2)) ? time_type'(2) : cfg.slot_time;
      low   = '0;
      last_read_in = last_read_ff;

      // Command start, or reject while busy
      if (phase_ff == PH_IDLE) begin
         t  = '0;
         bi = '0;
         case (op)
            OP_RESET: begin
               ph   = PH_RREC;
               pres = 1'b0;
            end
            OP_WRITE: begin
               ph = PH_WSLOT;
               sb = req_ff.data_byte;
            end
            OP_READ: begin
               ph = PH_RSLOT;
               sb = '0;
            end
            default: ;
         endcase
      end else if (op != OP_TICK) begin
         rej = 1'b1;
      end

      // Phase behaviour
      unique case (ph)
         PH_IDLE: ;
         PH_RREC: begin
            len = at_least_one(cfg.recovery_time);
            nxt = PH_RLOW;
         end
         PH_RLOW: begin
            drive = 1'b1;
            len   = at_least_one(cfg.reset_low_time);
            nxt   = PH_RDLY;
         end
         PH_RDLY: begin
            len = at_least_one(cfg.presence_delay);
            nxt = PH_RWIN;
         end
         PH_RWIN: begin
            len = at_least_one(cfg.presence_window);
            if (!req_ff.line_level) begin
               pres = 1'b1;
               jump = 1'b1;
               nxt  = PH_RHIGH;
            end
         end
         PH_RHIGH: begin
            len = at_least_one(cfg.reset_high_time);
         end
         PH_WSLOT: begin
            len   = slen;
            low   = sb[bi] ? clamp_in_slot(cfg.write_one_low_time, slen) : slen;
            drive = (t < low);
            nxt   = PH_WREC;
         end
         PH_WREC: begin
            len = at_least_one(cfg.recovery_time);
            nxt = (bi == 3'd7) ? PH_IDLE : PH_WSLOT;
         end
         PH_RSLOT: begin
            len   = slen;
            drive = (t == '0);
            if (t == clamp_in_slot(cfg.sample_delay, slen)) begin
               sb[bi] = sb[bi] | req_ff.line_level;
            end
            nxt = PH_RDREC;
         end
         PH_RDREC: begin
            len = at_least_one(cfg.recovery_time);
            nxt = (bi == 3'd7) ? PH_IDLE : PH_RSLOT;
         end
         default: begin
            jump = 1'b1;
         end
      endcase

      // Phase end and counter update
      phase_in      = ph;
      tick_count_in = t;
      if (ph != PH_IDLE) begin
         fin = jump || (({1'b0, t} + 11'd1) >= {1'b0, len});
         if (fin) begin
            if ((ph == PH_WREC || ph == PH_RDREC) && nxt != PH_IDLE) begin
               bi = bi + 3'd1;
            end
            if (ph == PH_RDREC && nxt == PH_IDLE) begin
               last_read_in = sb;
            end
            done          = (nxt == PH_IDLE);
            phase_in      = nxt;
            tick_count_in = '0;
         end else begin
            tick_count_in = t + time_type'(1);
         end
      end
      bit_index_in  = bi;
      shift_byte_in = sb;
      presence_in   = pres;

      rsp_in.drive_low        = drive;
      rsp_in.busy_res         = (ph != PH_IDLE);
      rsp_in.done_res         = done;
      rsp_in.device_present   = pres;
      rsp_in.read_data        = last_read_in;
      rsp_in.command_rejected = rej;
   end

   // Sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         tick_count_ff <= '0;
         bit_index_ff  <= '0;
         shift_byte_ff <= '0;
         presence_ff   <= 1'b0;
         last_read_ff  <= '0;
      end else if (advance) begin
         phase_ff      <= phase_in;
         tick_count_ff <= tick_count_in;
         bit_index_ff  <= bit_index_in;
         shift_byte_ff <= shift_byte_in;
         presence_ff   <= presence_in;
         last_read_ff  <= last_read_in;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef SYNTHESIS
   // Counter is parked at zero whenever the sequencer is idle
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> tick_count_ff == '0)
      else $error("tick counter running while idle");

   // Bus is only pulled low during a command
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.drive_low |-> rsp_ff.busy_res)
      else $error("bus driven low while not busy");

   // An accepted request reaches the input register
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> in_valid_ff)
      else $error("accepted request lost");

   // A done response leaves the sequencer idle
   assert property (@(posedge clock) disable iff (reset)
      advance && rsp_in.done_res |=> phase_ff == PH_IDLE)
      else $error("sequencer not idle after done");
`endif

endmodule

[hw/rtl/owbm_csr.sv]
// ----------------------------------------------------------------------------
// owbm_csr
// Timing register file of the 1-Wire bus master.
// ----------------------------------------------------------------------------
module owbm_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [2:0]            csr_index,
   input  owbm_pkg::time_type    csr_data,
   output owbm_pkg::cfg_type     cfg
);
   import owbm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_RECOVERY:   cfg_in.recovery_time      = csr_data;
            CSR_RESET_LOW:  cfg_in.reset_low_time     = csr_data;
            CSR_RESET_HIGH: cfg_in.reset_high_time    = csr_data;
            CSR_PRES_DELAY: cfg_in.presence_delay     = csr_data;
            CSR_PRES_WIN:   cfg_in.presence_window    = csr_data;
            CSR_SLOT:       cfg_in.slot_time          = csr_data;
            CSR_WRITE_ONE:  cfg_in.write_one_low_time = csr_data;
            CSR_SAMPLE:     cfg_in.sample_delay       = csr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.recovery_time      <= RecoveryReset;
         cfg_ff.reset_low_time     <= ResetLowReset;
         cfg_ff.reset_high_time    <= ResetHighReset;
         cfg_ff.presence_delay     <= PresDelayReset;
         cfg_ff.presence_window    <= PresWinReset;
         cfg_ff.slot_time          <= SlotReset;
         cfg_ff.write_one_low_time <= WriteOneReset;
         cfg_ff.sample_delay       <= SampleReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[test/tb_one_wire_bus_master.sv]
// ----------------------------------------------------------------------------
// tb_one_wire_bus_master
// Self-checking bench for the tick-driven 1-Wire bus master.
// ----------------------------------------------------------------------------
// Every request is one bus tick. A bit-accurate model of the sequencer runs
// alongside the block and predicts each response at request acceptance; the
// responses are checked in order, field by field. A short directed table
// covers the idle state after reset, resets with and without presence, the
// byte extremes and a command while busy. Random traffic then runs under a
// series of timing settings, from all-zero registers up to the largest values.
// ----------------------------------------------------------------------------
module tb_one_wire_bus_master;
   timeunit 1ns;
   timeprecision 1ps;

   import owbm_pkg::*;

   // Model state of the bus sequencer
   typedef struct {
      phase_type    phase;
      time_type     count;
      logic [2:0]   bit_idx;
      logic [7:0]   shift;
      logic         present;
      logic [7:0]   last_byte;
   } bus_state_type;

   // One row of the directed table
   typedef struct packed {
      logic       retime;
      op_type     op;
      logic [7:0] data;
      logic       line;
      int         reps;
      logic       typed;
      rsp_type    want;
   } plan_row_type;

   localparam rsp_type IDLE_RSP = '0;
   // Read arriving while the reset pulse is being driven
   localparam rsp_type REJECT_IN_LOW = '{drive_low: 1'b1, busy_res: 1'b1, done_res: 1'b0,
                                         device_present: 1'b0, read_data: 8'h00,
                                         command_rejected: 1'b1};

   localparam cfg_type TIMING_DIRECT = '{recovery_time: 10'd1, reset_low_time: 10'd3,
      reset_high_time: 10'd2, presence_delay: 10'd1, presence_window: 10'd3,
      slot_time: 10'd4, write_one_low_time: 10'd1, sample_delay: 10'd2};
   localparam cfg_type TIMING_ZERO = '0;
   localparam cfg_type TIMING_SLOT_ONE = '{recovery_time: 10'd2, reset_low_time: 10'd1,
      reset_high_time: 10'd1, presence_delay: 10'd2, presence_window: 10'd1,
      slot_time: 10'd1, write_one_low_time: 10'd0, sample_delay: 10'd9};
   localparam cfg_type TIMING_RESET_MAX = '{recovery_time: 10'd1, reset_low_time: 10'd1023,
      reset_high_time: 10'd1023, presence_delay: 10'd1023, presence_window: 10'd1023,
      slot_time: 10'd2, write_one_low_time: 10'd1023, sample_delay: 10'd1023};
   localparam cfg_type TIMING_SLOT_MAX = '{recovery_time: 10'd1023, reset_low_time: 10'd4,
      reset_high_time: 10'd4, presence_delay: 10'd4, presence_window: 10'd4,
      slot_time: 10'd1023, write_one_low_time: 10'd1022, sample_delay: 10'd1022};
   localparam cfg_type TIMING_DEFAULT = '{recovery_time: RecoveryReset,
      reset_low_time: ResetLowReset, reset_high_time: ResetHighReset,
      presence_delay: PresDelayReset, presence_window: PresWinReset,
      slot_time: SlotReset, write_one_low_time: WriteOneReset, sample_delay: SampleReset};

   localparam plan_row_type DIRECTED_PLAN [17] = '{
      '{1'b0, OP_TICK,  8'h00, 1'b1,  1, 1'b1, IDLE_RSP},
      '{1'b0, OP_TICK,  8'hFF, 1'b0,  1, 1'b1, IDLE_RSP},
      '{1'b1, OP_RESET, 8'h00, 1'b1,  1, 1'b0, IDLE_RSP},
      '{1'b0, OP_READ,  8'h3C, 1'b1,  1, 1'b1, REJECT_IN_LOW},
      '{1'b0, OP_TICK,  8'h00, 1'b1, 10, 1'b0, IDLE_RSP},
      '{1'b0, OP_RESET, 8'hFF, 1'b0,  1, 1'b0, IDLE_RSP},
      '{1'b0, OP_TICK,  8'h00, 1'b0, 10, 1'b0, IDLE_RSP},
      '{1'b0, OP_WRITE, 8'hA5, 1'b1,  1, 1'b0, IDLE_RSP},
      '{1'b0, OP_TICK,  8'h5A, 1'b1, 45, 1'b0, IDLE_RSP},
      '{1'b0, OP_WRITE, 8'h00, 1'b1,  1, 1'b0, IDLE_RSP},
      '{1'b0, OP_TICK,  8'h00, 1'b1, 45, 1'b0, IDLE_RSP},
      '{1'b0, OP_WRITE, 8'hFF, 1'b0,  1, 1'b0, IDLE_RSP},
      '{1'b0, OP_TICK,  8'hFF, 1'b0, 45, 1'b0, IDLE_RSP},
      '{1'b0, OP_READ,  8'hFF, 1'b0,  1, 1'b0, IDLE_RSP},
      '{1'b0, OP_TICK,  8'h00, 1'b0, 45, 1'b0, IDLE_RSP},
      '{1'b0, OP_READ,  8'h00, 1'b1,  1, 1'b0, IDLE_RSP},
      '{1'b0, OP_TICK,  8'h00, 1'b1, 45, 1'b0, IDLE_RSP}
   };

   localparam op_type COMMAND_OPS [3] = '{OP_RESET, OP_WRITE, OP_READ};

   logic      clock = 1'b0;
   logic      reset;
   logic      req_valid;
   logic      req_ready;
   req_type   req_payload;
   logic      rsp_valid;
   logic      rsp_ready;
   rsp_type   rsp_payload;
   logic      csr_valid;
   logic      csr_ready;
   logic [2:0] csr_index;
   time_type  csr_data;

   bus_state_type bus_now;
   time_type      timing_regs [8];
   rsp_type       expected_rsps [$];
   int            error_count;
   logic          gaps_on;
   logic          hold_rsp;
   int            low_share;

   one_wire_bus_master uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #2 clock = ~clock;

   // Phase lengths: zero still takes one tick
   function automatic int unsigned ticks_or_one(time_type v);
      return (v == '0) ? 32'd1 : 32'(v);
   endfunction

   function automatic int unsigned slot_ticks();
      return (timing_regs[CSR_SLOT] < 10'd2) ? 32'd2 : 32'(timing_regs[CSR_SLOT]);
   endfunction

   // Points inside a slot are kept to 1 .. len-1
   function automatic int unsigned within_slot(time_type v, int unsigned len);
      if (v == '0) return 1;
      if (32'(v) > len - 1) return len - 1;
      return 32'(v);
   endfunction

   // One bus tick of the sequencer: returns the response, n is the next state
   function automatic rsp_type owbm_tick(input bus_state_type s, input req_type r,
                                         output bus_state_type n);
      rsp_type     res;
      int unsigned len;
      int unsigned t;
      int unsigned low;
      phase_type   nxt;
      logic        jump;
      logic        fin;
      n = s;
      res = '0;
      len = 1;
      nxt = PH_IDLE;
      jump = 1'b0;
      // command start, or rejection while busy
      if (n.phase == PH_IDLE) begin
         if (r.operation != OP_TICK) begin
            n.count = '0;
            n.bit_idx = '0;
            case (r.operation)
               OP_RESET: begin
                  n.phase = PH_RREC;
                  n.present = 1'b0;
               end
               OP_WRITE: begin
                  n.phase = PH_WSLOT;
                  n.shift = r.data_byte;
               end
               default: begin
                  n.phase = PH_RSLOT;
                  n.shift = '0;
               end
            endcase
         end
      end else if (r.operation != OP_TICK) begin
         res.command_rejected = 1'b1;
      end
      if (n.phase != PH_IDLE) begin
         t = 32'(n.count);
         res.busy_res = 1'b1;
         case (n.phase)
            PH_RREC: begin
               len = ticks_or_one(timing_regs[CSR_RECOVERY]);
               nxt = PH_RLOW;
            end
            PH_RLOW: begin
               res.drive_low = 1'b1;
               len = ticks_or_one(timing_regs[CSR_RESET_LOW]);
               nxt = PH_RDLY;
            end
            PH_RDLY: begin
               len = ticks_or_one(timing_regs[CSR_PRES_DELAY]);
               nxt = PH_RWIN;
            end
            PH_RWIN: begin
               len = ticks_or_one(timing_regs[CSR_PRES_WIN]);
               // a low line is a presence pulse: window closes at once
               if (!r.line_level) begin
                  n.present = 1'b1;
                  jump = 1'b1;
                  nxt = PH_RHIGH;
               end
            end
            PH_RHIGH: begin
               len = ticks_or_one(timing_regs[CSR_RESET_HIGH]);
            end
            PH_WSLOT: begin
               len = slot_ticks();
               low = n.shift[n.bit_idx] ? within_slot(timing_regs[CSR_WRITE_ONE], len) : len;
               res.drive_low = (t < low);
               nxt = PH_WREC;
            end
            PH_WREC: begin
               len = ticks_or_one(timing_regs[CSR_RECOVERY]);
               nxt = (n.bit_idx == 3'd7) ? PH_IDLE : PH_WSLOT;
            end
            PH_RSLOT: begin
               len = slot_ticks();
               res.drive_low = (t == 0);
               if (t == within_slot(timing_regs[CSR_SAMPLE], len))
                  n.shift[n.bit_idx] = n.shift[n.bit_idx] | r.line_level;
               nxt = PH_RDREC;
            end
            PH_RDREC: begin
               len = ticks_or_one(timing_regs[CSR_RECOVERY]);
               nxt = (n.bit_idx == 3'd7) ? PH_IDLE : PH_RSLOT;
            end
            default: begin
               jump = 1'b1;
            end
         endcase
         fin = jump || (t + 1 >= len);
         if (fin) begin
            if ((n.phase == PH_WREC || n.phase == PH_RDREC) && nxt != PH_IDLE)
               n.bit_idx = n.bit_idx + 3'd1;
            if (n.phase == PH_RDREC && nxt == PH_IDLE)
               n.last_byte = n.shift;
            if (nxt == PH_IDLE)
               res.done_res = 1'b1;
            n.phase = nxt;
            n.count = '0;
         end else begin
            n.count = time_type'(t + 1);
         end
      end
      res.device_present = n.present;
      res.read_data = n.last_byte;
      return res;
   endfunction

   // Mostly back-to-back, sometimes short gaps, rarely long ones
   function automatic int idle_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (!gaps_on || pick < 70) return 0;
      if (pick < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic bus_line();
      return ($urandom_range(0, 15) < low_share) ? 1'b0 : 1'b1;
   endfunction

   // Random tick: commands mostly when idle, some rejected ones, often on the done tick
   function automatic req_type random_request();
      req_type       r;
      rsp_type       peek;
      bus_state_type scratch;
      r.data_byte = 8'($urandom);
      r.line_level = bus_line();
      r.operation = OP_TICK;
      peek = owbm_tick(bus_now, r, scratch);
      if (bus_now.phase == PH_IDLE) begin
         if ($urandom_range(0, 3) == 0) begin
            r.operation = COMMAND_OPS[$urandom_range(0, 2)];
            low_share = $urandom_range(0, 16);
         end
      end else if ((peek.done_res && $urandom_range(0, 1) == 0) ||
                   $urandom_range(0, 39) == 0) begin
         r.operation = COMMAND_OPS[$urandom_range(0, 2)];
      end
      return r;
   endfunction

   // Offer one request, predict its response on acceptance, then maybe pause
   task automatic send_request(input req_type r, input logic typed, input rsp_type want);
      rsp_type       predicted;
      bus_state_type nxt;
      int            gap;
      req_payload <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predicted = owbm_tick(bus_now, r, nxt);
      bus_now = nxt;
      expected_rsps.push_back(typed ? want : predicted);
      @(negedge clock);
      gap = idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Write all timing registers once the block has drained
   task automatic load_timing(input cfg_type c);
      time_type      vals [8];
      csr_index_type idx;
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      vals[CSR_RECOVERY]   = c.recovery_time;
      vals[CSR_RESET_LOW]  = c.reset_low_time;
      vals[CSR_RESET_HIGH] = c.reset_high_time;
      vals[CSR_PRES_DELAY] = c.presence_delay;
      vals[CSR_PRES_WIN]   = c.presence_window;
      vals[CSR_SLOT]       = c.slot_time;
      vals[CSR_WRITE_ONE]  = c.write_one_low_time;
      vals[CSR_SAMPLE]     = c.sample_delay;
      idx = CSR_RECOVERY;
      repeat (8) begin
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data <= vals[idx];
         do @(posedge clock); while (!csr_ready);
         timing_regs[idx] = vals[idx];
         @(negedge clock);
         idx = idx.next();
      end
      csr_valid <= 1'b0;
   endtask

   function automatic cfg_type compact_timing();
      cfg_type c;
      c.recovery_time      = time_type'($urandom_range(1, 4));
      c.reset_low_time     = time_type'($urandom_range(1, 6));
      c.reset_high_time    = time_type'($urandom_range(1, 6));
      c.presence_delay     = time_type'($urandom_range(1, 4));
      c.presence_window    = time_type'($urandom_range(1, 8));
      c.slot_time          = time_type'($urandom_range(2, 9));
      c.write_one_low_time = time_type'($urandom_range(1, 12));
      c.sample_delay       = time_type'($urandom_range(1, 12));
      return c;
   endfunction

   // Random traffic under one timing setting; a command may still be running
   // when the next setting is loaded
   task automatic run_random(input cfg_type c, input int count, input logic gaps,
                             input int hold_at);
      int i;
      load_timing(c);
      gaps_on = gaps;
      for (i = 0; i < count; i++) begin
         if (i == hold_at) hold_rsp = 1'b1;
         send_request(random_request(), 1'b0, IDLE_RSP);
      end
      gaps_on = 1'b1;
   endtask

   // Response side: random stalls, and one long hold-off when asked
   initial begin
      rsp_ready = 1'b0;
      forever begin : rsp_side
         int stall_left;
         int pick;
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (300) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            pick = $urandom_range(0, 99);
            if (gaps_on && pick >= 80)
               stall_left = (pick < 97) ? $urandom_range(1, 3) : $urandom_range(10, 40);
         end
      end
   end

   task automatic field_check(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // Compare each response with the oldest prediction
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response, expected none, got %p", $time, rsp_payload);
            error_count++;
         end else begin
            want = expected_rsps.pop_front();
            field_check("drive_low", 8'(want.drive_low), 8'(rsp_payload.drive_low));
            field_check("busy_res", 8'(want.busy_res), 8'(rsp_payload.busy_res));
            field_check("done_res", 8'(want.done_res), 8'(rsp_payload.done_res));
            field_check("device_present", 8'(want.device_present),
                        8'(rsp_payload.device_present));
            field_check("read_data", want.read_data, rsp_payload.read_data);
            field_check("command_rejected", 8'(want.command_rejected),
                        8'(rsp_payload.command_rejected));
         end
      end
   end

   // Main sequence
   initial begin : stimulus
      req_type r;
      int      i;
      int      k;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_valid = 1'b0;
      csr_index = CSR_RECOVERY;
      csr_data = '0;
      gaps_on = 1'b1;
      hold_rsp = 1'b0;
      low_share = 8;
      error_count = 0;
      timing_regs[CSR_RECOVERY]   = RecoveryReset;
      timing_regs[CSR_RESET_LOW]  = ResetLowReset;
      timing_regs[CSR_RESET_HIGH] = ResetHighReset;
      timing_regs[CSR_PRES_DELAY] = PresDelayReset;
      timing_regs[CSR_PRES_WIN]   = PresWinReset;
      timing_regs[CSR_SLOT]       = SlotReset;
      timing_regs[CSR_WRITE_ONE]  = WriteOneReset;
      timing_regs[CSR_SAMPLE]     = SampleReset;
      bus_now = '{PH_IDLE, '0, '0, '0, 1'b0, '0};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      for (i = 0; i < $size(DIRECTED_PLAN); i++) begin
         if (DIRECTED_PLAN[i].retime) load_timing(TIMING_DIRECT);
         r.operation = DIRECTED_PLAN[i].op;
         r.data_byte = DIRECTED_PLAN[i].data;
         r.line_level = DIRECTED_PLAN[i].line;
         for (k = 0; k < DIRECTED_PLAN[i].reps; k++)
            send_request(r, DIRECTED_PLAN[i].typed && k == 0, DIRECTED_PLAN[i].want);
      end

      // random traffic over a range of timing settings
      run_random(compact_timing(), 60, 1'b1, 20);
      run_random(TIMING_ZERO, 30, 1'b0, -1);
      run_random(TIMING_SLOT_ONE, 30, 1'b1, -1);
      run_random(TIMING_RESET_MAX, 20, 1'b1, -1);
      run_random(compact_timing(), 40, 1'b1, -1);
      run_random(TIMING_SLOT_MAX, 15, 1'b1, -1);
      run_random(TIMING_DEFAULT, 25, 1'b1, -1);
      run_random(compact_timing(), 30, 1'b0, -1);

      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Watchdog
   initial begin
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
